// ===== rtl/core/block_bitmap_allocator_assert.svh =====
// Assertion macros for the block bitmap allocator.
`ifndef BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset
`define BBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("block_bitmap_allocator: check failed");

// Next-cycle implication, clocked on clk_i, off during reset
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("block_bitmap_allocator: check failed");

`endif

// ===== rtl/core/bba_pkg.sv =====
// Shared constants, types and helpers of the block bitmap allocator.
package bba_pkg;

  localparam int unsigned WORD_W         = 8;
  localparam int unsigned WORD_LW        = 3;
  localparam int unsigned BLK_W          = 10;
  localparam int unsigned CFG_W          = 11;
  localparam int unsigned ST_W           = 2;
  localparam int unsigned NUM_BLOCKS_DEF = 1024;
  localparam int unsigned TOTAL_RST      = 1024;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK           = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_FREE      = 2'd1;
  localparam logic [ST_W-1:0] ST_ALREADY_FREE = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE        = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic            clr;        // write zero at sweep counter, advance
    logic            take;       // capture request
    logic            top_rd;     // read top summary entry
    logic            top_inc;    // step to next top summary entry
    logic            grp_rd;     // read group summary entry
    logic            wrd_rd;     // read bitmap word
    logic            alloc_wr;   // mark found block used
    logic            free_rd;    // read all levels at request block
    logic            free_wr;    // mark request block free
    logic            res_set;    // capture result
    logic            res_alloc;  // result carries the found block number
    logic [ST_W-1:0] res_code;
    logic            out_load;   // move result into the output register
  } bba_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic in_free;
    logic top_full;
    logic top_last;
    logic cand_ok;
    logic free_ok;
    logic bit_used;
  } bba_sts_t;

  // Index of the lowest clear bit of a word (zero for a full word)
  function automatic logic [WORD_LW-1:0] ffz(input logic [WORD_W-1:0] w);
    logic [WORD_LW-1:0] r;
    logic               found;
    r     = '0;
    found = 1'b0;
    for (int i = 0; i < WORD_W; i++) begin
      if (!found && !w[i]) begin
        r     = WORD_LW'(i);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  // One-hot mask for a bit position within a word
  function automatic logic [WORD_W-1:0] bit_mask(input logic [WORD_LW-1:0] idx);
    logic [WORD_W-1:0] m;
    m      = '0;
    m[idx] = 1'b1;
    return m;
  endfunction

endpackage

// ===== rtl/core/bba_datapath.sv =====
// Datapath: three-level bitmap memories, limit register, indices and result registers.
module bba_datapath import bba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             operation_i,
  input  logic [BLK_W-1:0] block_number_i,
  input  bba_cmd_t         cmd_i,
  output bba_sts_t         sts_o,
  output logic [BLK_W-1:0] allocated_block_o,
  output logic [ST_W-1:0]  status_o
);

  // Block index width (at least the port width), then word, group and top indices
  localparam int unsigned NB_LW   = $clog2(NUM_BLOCKS);
  localparam int unsigned BW      = (NB_LW > BLK_W) ? NB_LW : BLK_W;
  localparam int unsigned WW      = BW - WORD_LW;
  localparam int unsigned GW      = WW - WORD_LW;
  localparam int unsigned TW      = GW - WORD_LW;
  localparam int unsigned LW      = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned CW      = BW + 1;
  localparam int unsigned KW      = (LW > CFG_W) ? LW : CFG_W;
  localparam int unsigned LIM_RST = (TOTAL_RST > NUM_BLOCKS) ? NUM_BLOCKS : TOTAL_RST;

  // Level 0: used bits; level 1: word-full bits; level 2: group-full bits
  logic [WORD_W-1:0] lvl0_mem [2**WW];
  logic [WORD_W-1:0] lvl1_mem [2**GW];
  logic [WORD_W-1:0] lvl2_mem [2**TW];

  logic [WORD_W-1:0] r0_q, r1_q, r2_q;
  logic [LW-1:0]     lim_q, lim_d;
  logic [KW-1:0]     cfg_x;
  logic [WW-1:0]     clr_q, clr_d;
  logic [BW-1:0]     blk_q, blk_d;
  logic [TW-1:0]     t_q, t_d;
  logic [GW-1:0]     g_q, g_d;
  logic [WW-1:0]     w_q, w_d;
  logic [BLK_W-1:0]  res_blk_q, res_blk_d;
  logic [ST_W-1:0]   res_st_q, res_st_d;
  logic [BLK_W-1:0]  out_blk_q, out_blk_d;
  logic [ST_W-1:0]   out_st_q, out_st_d;

  logic [WORD_LW-1:0] f0, f1, f2;
  logic [GW-1:0]      g_alloc;
  logic [WW-1:0]      w_alloc;
  logic [BW-1:0]      b_alloc;
  logic [TW-1:0]      blk_t;
  logic [GW-1:0]      blk_g;
  logic [WW-1:0]      blk_w;

  logic              re0, re1, re2, we0, we1, we2;
  logic [WW-1:0]     ra0, wa0;
  logic [GW-1:0]     ra1, wa1;
  logic [TW-1:0]     ra2, wa2;
  logic [WORD_W-1:0] wd0, wd1, wd2;
  logic [WORD_W-1:0] set0, set1, set2;

  // Search candidates from the held read data
  assign f0      = ffz(r0_q);
  assign f1      = ffz(r1_q);
  assign f2      = ffz(r2_q);
  assign g_alloc = {t_q, f2};
  assign w_alloc = {g_q, f1};
  assign b_alloc = {w_q, f0};

  // Indices of the request block
  assign blk_t = blk_q[BW-1 -: TW];
  assign blk_g = blk_q[BW-1 -: GW];
  assign blk_w = blk_q[BW-1 -: WW];

  // Limit register, clipped to capacity on write
  assign cfg_x = KW'(cfg_wdata_i);
  always_comb begin
    lim_d = lim_q;
    if (cfg_we_i) begin
      lim_d = (cfg_x > KW'(NUM_BLOCKS)) ? LW'(NUM_BLOCKS) : LW'(cfg_x);
    end
  end

  // Sweep counter and indices
  always_comb begin
    clr_d = cmd_i.clr ? clr_q + 1'b1 : clr_q;
    blk_d = cmd_i.take ? BW'(block_number_i) : blk_q;
    t_d   = t_q;
    g_d   = g_q;
    w_d   = w_q;
    if (cmd_i.take)    t_d = '0;
    if (cmd_i.top_inc) t_d = t_q + 1'b1;
    if (cmd_i.grp_rd)  g_d = g_alloc;
    if (cmd_i.wrd_rd)  w_d = w_alloc;
    if (cmd_i.free_rd) begin
      t_d = blk_t;
      g_d = blk_g;
      w_d = blk_w;
    end
  end

  // Memory read controls
  assign re2 = cmd_i.top_rd | cmd_i.free_rd;
  assign re1 = cmd_i.grp_rd | cmd_i.free_rd;
  assign re0 = cmd_i.wrd_rd | cmd_i.free_rd;
  assign ra2 = cmd_i.free_rd ? blk_t : t_q;
  assign ra1 = cmd_i.free_rd ? blk_g : g_alloc;
  assign ra0 = cmd_i.free_rd ? blk_w : w_alloc;

  // Memory write controls: clear sweep, allocate set, free clear
  assign set0 = r0_q | bit_mask(f0);
  assign set1 = r1_q | bit_mask(w_q[WORD_LW-1:0]);
  assign set2 = r2_q | bit_mask(g_q[WORD_LW-1:0]);

  always_comb begin
    we0 = 1'b0;
    we1 = 1'b0;
    we2 = 1'b0;
    wa0 = w_q;
    wa1 = g_q;
    wa2 = t_q;
    wd0 = '0;
    wd1 = '0;
    wd2 = '0;
    if (cmd_i.clr) begin
      we0 = 1'b1;
      we1 = 1'b1;
      we2 = 1'b1;
      wa0 = clr_q;
      wa1 = clr_q[GW-1:0];
      wa2 = clr_q[TW-1:0];
    end else if (cmd_i.alloc_wr) begin
      // summaries only change when the word, then the group, fills up
      we0 = 1'b1;
      we1 = &set0;
      we2 = (&set0) & (&set1);
      wd0 = set0;
      wd1 = set1;
      wd2 = set2;
    end else if (cmd_i.free_wr) begin
      we0 = 1'b1;
      we1 = 1'b1;
      we2 = 1'b1;
      wd0 = r0_q & ~bit_mask(blk_q[WORD_LW-1:0]);
      wd1 = r1_q & ~bit_mask(w_q[WORD_LW-1:0]);
      wd2 = r2_q & ~bit_mask(g_q[WORD_LW-1:0]);
    end
  end

  // Bitmap memories, registered read data held until the next read
  always_ff @(posedge clk_i) begin
    if (we0) lvl0_mem[wa0] <= wd0;
    if (re0) r0_q <= lvl0_mem[ra0];
  end

  always_ff @(posedge clk_i) begin
    if (we1) lvl1_mem[wa1] <= wd1;
    if (re1) r1_q <= lvl1_mem[ra1];
  end

  always_ff @(posedge clk_i) begin
    if (we2) lvl2_mem[wa2] <= wd2;
    if (re2) r2_q <= lvl2_mem[ra2];
  end

  // Result capture and output register
  always_comb begin
    res_blk_d = res_blk_q;
    res_st_d  = res_st_q;
    out_blk_d = out_blk_q;
    out_st_d  = out_st_q;
    if (cmd_i.res_set) begin
      res_st_d  = cmd_i.res_code;
      res_blk_d = cmd_i.res_alloc ? b_alloc[BLK_W-1:0] : '0;
    end
    if (cmd_i.out_load) begin
      out_blk_d = res_blk_q;
      out_st_d  = res_st_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LW'(LIM_RST);
      clr_q <= '0;
    end else begin
      lim_q <= lim_d;
      clr_q <= clr_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    blk_q     <= blk_d;
    t_q       <= t_d;
    g_q       <= g_d;
    w_q       <= w_d;
    res_blk_q <= res_blk_d;
    res_st_q  <= res_st_d;
    out_blk_q <= out_blk_d;
    out_st_q  <= out_st_d;
  end

  // Status to the controller
  always_comb begin
    sts_o          = '0;
    sts_o.clr_last = &clr_q;
    sts_o.in_free  = operation_i;
    sts_o.top_full = &r2_q;
    sts_o.top_last = &t_q;
    sts_o.cand_ok  = CW'(b_alloc) < CW'(lim_q);
    sts_o.free_ok  = CW'(blk_q) < CW'(lim_q);
    sts_o.bit_used = r0_q[blk_q[WORD_LW-1:0]];
  end

  assign allocated_block_o = out_blk_q;
  assign status_o          = out_st_q;

endmodule

// ===== rtl/core/bba_ctrl.sv =====
// Controller: sequences the clear sweep, the allocate search and the free update.
module bba_ctrl import bba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  bba_sts_t sts_i,
  output bba_cmd_t cmd_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_TOP   = 4'd2;
  localparam logic [3:0] S_GRP   = 4'd3;
  localparam logic [3:0] S_WRD   = 4'd4;
  localparam logic [3:0] S_BIT   = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_FWR   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = sts_i.in_free ? S_FRD : S_TOP;
        end
      end
      S_TOP: begin
        cmd_o.top_rd = 1'b1;
        state_d      = S_GRP;
      end
      S_GRP: begin
        if (!sts_i.top_full) begin
          cmd_o.grp_rd = 1'b1;
          state_d      = S_WRD;
        end else if (sts_i.top_last) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = ST_NO_FREE;
          state_d        = S_FIN;
        end else begin
          cmd_o.top_inc = 1'b1;
          state_d       = S_TOP;
        end
      end
      S_WRD: begin
        cmd_o.wrd_rd = 1'b1;
        state_d      = S_BIT;
      end
      S_BIT: begin
        // lowest free block found; refuse it if at or past the limit
        cmd_o.res_set = 1'b1;
        if (sts_i.cand_ok) begin
          cmd_o.alloc_wr  = 1'b1;
          cmd_o.res_alloc = 1'b1;
          cmd_o.res_code  = ST_OK;
        end else begin
          cmd_o.res_code = ST_NO_FREE;
        end
        state_d = S_FIN;
      end
      S_FRD: begin
        if (sts_i.free_ok) begin
          cmd_o.free_rd = 1'b1;
          state_d       = S_FWR;
        end else begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = ST_RANGE;
          state_d        = S_FIN;
        end
      end
      S_FWR: begin
        cmd_o.res_set = 1'b1;
        if (sts_i.bit_used) begin
          cmd_o.free_wr  = 1'b1;
          cmd_o.res_code = ST_OK;
        end else begin
          cmd_o.res_code = ST_ALREADY_FREE;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output slot occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/block_bitmap_allocator.sv =====
// Block bitmap allocator top level: first-fit block allocation over a bitmap.
// Usage notes: after reset the block sweeps its bitmap clear, one word of eight
// blocks per cycle, and takes no request until the sweep has cleared the last
// word; configuration writes are taken during the sweep. The bitmap sits in
// three levels of memory: used bits, word-full bits and group-full bits, each
// behind one registered read port. A free request steps through a range check
// with read of all levels, write back and output load, or through the range
// check and output load alone when the block is out of range. An allocate
// reads the top summary one entry at a time, moving on to the next entry for
// every 512-block region that it finds full, then reads the group and word
// entries, checks the limit, marks the block used if it is within the limit
// and loads the output. The next request is accepted once the result is in its
// output register slot, even if the previous result has not yet been taken.
`include "block_bitmap_allocator_assert.svh"

module block_bitmap_allocator import bba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             operation_i,
  input  logic [BLK_W-1:0] block_number_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [BLK_W-1:0] allocated_block_o,
  output logic [ST_W-1:0]  status_o
);

  bba_cmd_t cmd;
  bba_sts_t sts;

  // Sequencer
  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Bitmap storage and result path
  bba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .operation_i       (operation_i),
    .block_number_i    (block_number_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .allocated_block_o (allocated_block_o),
    .status_o          (status_o)
  );

  // Checks
  `BBA_ASSERT_NEXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o)
  `BBA_ASSERT_NOW(a_load_into_free_slot, cmd.out_load, !out_valid_o || out_ready_i)
  `BBA_ASSERT_NOW(a_zero_block_on_refusal, out_valid_o && (status_o != ST_OK), allocated_block_o == '0)
  `BBA_ASSERT_NOW(a_rise_needs_load, $rose(out_valid_o), $past(cmd.out_load))

endmodule
